// ===== hw/rtl/lmwq_pkg.sv =====
// shared constants, types and codes for the lock manager
`default_nettype none
package lmwq_pkg;
    localparam int LOCK_SLOTS  = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int CLIENT_BITS = 8;

    // fixed field widths
    localparam int LOCK_W    = 64;
    localparam int CLIENT_W  = 8;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 3;

    // derived widths
    localparam int SLOT_W    = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int WADDR_W   = SLOT_W + QPTR_W;
    localparam int WAIT_DEPTH = 1 << WADDR_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_REPLY  = 2'd0,
        KIND_REVOKE = 2'd1,
        KIND_RETRY  = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_RETRY      = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_QUEUE_FULL = 3'd3,
        ST_NOT_HELD   = 3'd4
    } t_status;

    typedef enum logic {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_ACT,
        S_WRD,
        S_RETRY,
        S_REVOKE,
        S_REPLY
    } t_state;
endpackage
`default_nettype wire

// ===== hw/rtl/lmwq_if.sv =====
// request and response channel interfaces
`default_nettype none
interface lmwq_req_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [lmwq_pkg::LOCK_W-1:0]   lock_id;
    logic [lmwq_pkg::CLIENT_W-1:0] client_id;
    modport source (output valid, action, lock_id, client_id, input ready);
    modport sink   (input valid, action, lock_id, client_id, output ready);
endinterface

interface lmwq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lmwq_pkg::KIND_W-1:0]   kind;
    logic [lmwq_pkg::STATUS_W-1:0] status;
    logic [lmwq_pkg::CLIENT_W-1:0] target_client;
    logic [lmwq_pkg::LOCK_W-1:0]   lock_of_message;
    logic                          last;
    modport source (output valid, kind, status, target_client, lock_of_message, last,
                    input ready);
    modport sink   (input valid, kind, status, target_client, lock_of_message, last,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lmwq_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none
module lmwq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/lock_manager_with_waiter_queues_core.sv =====
// lock manager top: slot search sequencer, waiter queues and response register
//
// channel   dir  handshake      payload
// i_req     in   valid/ready    action, lock_id, client_id
// o_rsp     out  valid/ready    kind, status, target_client, lock_of_message, last
//
// one item at a time; i_req.ready is high only while the sequencer is idle
// slot search compares one stored tag a cycle through the lock ram and stops early when the
// lock matches a slot; then a decision state, a waiter ram read when a message is due, and
// one result per cycle while o_rsp is not stalled (1 to 3 results per item)
// synchronous active-low reset clears slot valid bits, queue heads and counts
// a stalled o_rsp holds the sequencer in its emit state
`default_nettype none
module lock_manager_with_waiter_queues_core (
    input wire logic i_clk,
    input wire logic i_rst_n,
    lmwq_req_if.sink   i_req,
    lmwq_rsp_if.source o_rsp
);
    import lmwq_pkg::*;

    t_state r_state, n_state;

    // request capture
    logic                   r_action, n_action;
    logic [LOCK_W-1:0]      r_lock, n_lock;
    logic [CLIENT_BITS-1:0] r_client, n_client;

    // search results
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_found, n_found;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_free_ok, n_free_ok;
    logic [SLOT_W-1:0] r_free, n_free;

    // per-slot queue state
    logic              r_valid [LOCK_SLOTS];
    logic              n_valid [LOCK_SLOTS];
    logic [QPTR_W-1:0] r_head  [LOCK_SLOTS];
    logic [QPTR_W-1:0] n_head  [LOCK_SLOTS];
    logic [CNT_W-1:0]  r_count [LOCK_SLOTS];
    logic [CNT_W-1:0]  n_count [LOCK_SLOTS];

    // result plan
    t_status            r_status, n_status;
    logic               r_do_retry, n_do_retry;
    logic               r_do_revoke, n_do_revoke;
    logic [CLIENT_BITS-1:0] r_tgt, n_tgt;

    // output register
    logic                   r_ov, n_ov;
    t_kind                  r_o_kind, n_o_kind;
    t_status                r_o_status, n_o_status;
    logic [CLIENT_BITS-1:0] r_o_tgt, n_o_tgt;
    logic [LOCK_W-1:0]      r_o_lock, n_o_lock;
    logic                   r_o_last, n_o_last;

    // ram ports
    logic               lk_we;
    logic [SLOT_W-1:0]  lk_waddr;
    logic [SLOT_W-1:0]  lk_raddr;
    logic [LOCK_W-1:0]  lk_rdata;
    logic               wt_we;
    logic [WADDR_W-1:0] wt_waddr;
    logic [WADDR_W-1:0] wt_raddr;
    logic [CLIENT_BITS-1:0] wt_rdata;

    // decision helpers
    logic [SLOT_W-1:0]  s;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   nc;
    logic [QPTR_W-1:0]  hd;
    logic [QPTR_W-1:0]  nh;
    logic [CNT_W:0]     tail_sum;
    logic [QPTR_W-1:0]  tail;
    logic               out_free;

    lmwq_ram #(.WIDTH(LOCK_W), .DEPTH(1 << SLOT_W)) u_lock_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (r_lock),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    lmwq_ram #(.WIDTH(CLIENT_BITS), .DEPTH(WAIT_DEPTH)) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (r_client),
        .i_raddr (wt_raddr),
        .o_rdata (wt_rdata)
    );

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_ov;
    assign o_rsp.kind            = r_o_kind;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.target_client   = CLIENT_W'(r_o_tgt);
    assign o_rsp.lock_of_message = r_o_lock;
    assign o_rsp.last            = r_o_last;

    assign out_free = !r_ov || o_rsp.ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int i = 0; i < LOCK_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_valid <= n_valid;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_lock      <= n_lock;
        r_client    <= n_client;
        r_idx       <= n_idx;
        r_found     <= n_found;
        r_slot      <= n_slot;
        r_free_ok   <= n_free_ok;
        r_free      <= n_free;
        r_status    <= n_status;
        r_do_retry  <= n_do_retry;
        r_do_revoke <= n_do_revoke;
        r_tgt       <= n_tgt;
        r_o_kind    <= n_o_kind;
        r_o_status  <= n_o_status;
        r_o_tgt     <= n_o_tgt;
        r_o_lock    <= n_o_lock;
        r_o_last    <= n_o_last;
    end

    // sequencer: search, decide, emit
    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_lock      = r_lock;
        n_client    = r_client;
        n_idx       = r_idx;
        n_found     = r_found;
        n_slot      = r_slot;
        n_free_ok   = r_free_ok;
        n_free      = r_free;
        n_valid     = r_valid;
        n_head      = r_head;
        n_count     = r_count;
        n_status    = r_status;
        n_do_retry  = r_do_retry;
        n_do_revoke = r_do_revoke;
        n_tgt       = r_tgt;
        n_ov        = r_ov && !o_rsp.ready;
        n_o_kind    = r_o_kind;
        n_o_status  = r_o_status;
        n_o_tgt     = r_o_tgt;
        n_o_lock    = r_o_lock;
        n_o_last    = r_o_last;
        lk_we       = 1'b0;
        lk_waddr    = r_free;
        lk_raddr    = r_idx;
        wt_we       = 1'b0;
        wt_waddr    = '0;
        wt_raddr    = '0;

        s   = r_found ? r_slot : r_free;
        cnt = r_found ? r_count[s] : '0;
        hd  = r_found ? r_head[s] : '0;
        nh  = hd;
        nc  = cnt;

        // tail position with wrap
        tail_sum = (CNT_W+1)'(hd) + (CNT_W+1)'(cnt);
        if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        tail = tail_sum[QPTR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_action  = i_req.action;
                    n_lock    = i_req.lock_id;
                    n_client  = i_req.client_id[CLIENT_BITS-1:0];
                    n_idx     = '0;
                    n_found   = 1'b0;
                    n_free_ok = 1'b0;
                    n_state   = S_SRD;
                end
            end
            S_SRD: begin
                lk_raddr = r_idx;
                n_state  = S_SCMP;
            end
            S_SCMP: begin
                // compare one stored tag, fetch the next
                lk_raddr = r_idx + SLOT_W'(1);
                if (r_valid[r_idx] && lk_rdata == r_lock) begin
                    n_found = 1'b1;
                    n_slot  = r_idx;
                    n_state = S_ACT;
                end else begin
                    if (!r_valid[r_idx] && !r_free_ok) begin
                        n_free_ok = 1'b1;
                        n_free    = r_idx;
                    end
                    if (r_idx == SLOT_W'(LOCK_SLOTS - 1)) begin
                        n_state = S_ACT;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
            end
            S_ACT: begin
                n_do_retry  = 1'b0;
                n_do_revoke = 1'b0;
                n_state     = S_REPLY;
                if (r_action == ACT_ACQUIRE) begin
                    if (!r_found && !r_free_ok) begin
                        n_status = ST_TABLE_FULL;
                    end else if (cnt >= CNT_W'(QUEUE_DEPTH)) begin
                        n_status = ST_QUEUE_FULL;
                    end else begin
                        // allocate a new slot when needed, then enqueue
                        if (!r_found) begin
                            n_valid[s] = 1'b1;
                            lk_we      = 1'b1;
                            lk_waddr   = s;
                        end
                        wt_we      = 1'b1;
                        wt_waddr   = {s, tail};
                        n_head[s]  = hd;
                        n_count[s] = cnt + CNT_W'(1);
                        if (cnt == '0) begin
                            n_status = ST_OK;
                        end else begin
                            n_status = ST_RETRY;
                            if (cnt == CNT_W'(1)) begin
                                n_do_revoke = 1'b1;
                                wt_raddr    = {s, hd};
                                n_state     = S_WRD;
                            end
                        end
                    end
                end else begin
                    if (!r_found) begin
                        n_status = ST_NOT_HELD;
                    end else begin
                        n_status = ST_OK;
                        if (cnt != '0) begin
                            nh = (hd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : hd + QPTR_W'(1);
                            nc = cnt - CNT_W'(1);
                        end
                        n_count[s] = nc;
                        if (nc != '0) begin
                            n_head[s]   = nh;
                            n_do_retry  = 1'b1;
                            n_do_revoke = (nc > CNT_W'(1));
                            wt_raddr    = {s, nh};
                            n_state     = S_WRD;
                        end else begin
                            n_valid[s] = 1'b0;
                            n_head[s]  = '0;
                        end
                    end
                end
            end
            S_WRD: begin
                n_tgt   = wt_rdata;
                n_state = r_do_retry ? S_RETRY : S_REVOKE;
            end
            S_RETRY: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_kind   = KIND_RETRY;
                    n_o_status = ST_OK;
                    n_o_tgt    = r_tgt;
                    n_o_lock   = r_lock;
                    n_o_last   = 1'b0;
                    n_state    = r_do_revoke ? S_REVOKE : S_REPLY;
                end
            end
            S_REVOKE: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_kind   = KIND_REVOKE;
                    n_o_status = ST_OK;
                    n_o_tgt    = r_tgt;
                    n_o_lock   = r_lock;
                    n_o_last   = 1'b0;
                    n_state    = S_REPLY;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_o_kind   = KIND_REPLY;
                    n_o_status = r_status;
                    n_o_tgt    = r_client;
                    n_o_lock   = r_lock;
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // while idle, any pending result is the final reply
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_ov) |-> r_o_last)
        else $error("non-final result pending while idle");

    // an accepted item makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("ready after accept");

    // a matched slot is a live slot
    a_found_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACT && r_found) |-> r_valid[r_slot])
        else $error("match on a free slot");

    // queue occupancy of a matched slot stays within depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACT && r_found) |-> r_count[r_slot] <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");
endmodule
`default_nettype wire

// ===== tb/tb_lock_manager_with_waiter_queues_core.sv =====
// testbench for the lock manager: directed and random lock traffic against a local predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_lock_manager_with_waiter_queues_core;
    import lmwq_pkg::*;

    typedef struct packed {
        t_kind                kind;
        t_status              status;
        logic [CLIENT_W-1:0]  target;
        logic [LOCK_W-1:0]    lock_id;
        logic                 last;
    } t_msg;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    lmwq_req_if req_ch();
    lmwq_rsp_if rsp_ch();

    lock_manager_with_waiter_queues_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic                slot_used [LOCK_SLOTS];
    logic [LOCK_W-1:0]   slot_tag  [LOCK_SLOTS];
    logic [CLIENT_W-1:0] waiters   [LOCK_SLOTS][QUEUE_DEPTH];
    int unsigned         q_head    [LOCK_SLOTS];
    int unsigned         q_count   [LOCK_SLOTS];

    t_msg pending_msgs[$];
    int   n_errors = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    // pool of lock ids for well-formed traffic
    logic [LOCK_W-1:0] lock_pool[24];

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    function automatic void push_msg(t_kind k, t_status st, logic [CLIENT_W-1:0] tgt,
                                     logic [LOCK_W-1:0] lk, logic lst);
        t_msg m;
        m.kind = k; m.status = st; m.target = tgt; m.lock_id = lk; m.last = lst;
        pending_msgs.insert(pending_msgs.size(), m);
    endfunction

    // works out the messages for one request and updates the lock table
    function automatic void predict_lock_request(t_action act, logic [LOCK_W-1:0] lk,
                                                 logic [CLIENT_W-1:0] cl);
        int s;
        int f;
        int unsigned pos;
        logic [CLIENT_W-1:0] hd;
        s = -1;
        f = -1;
        for (int i = 0; i < LOCK_SLOTS; i++)
            if (s < 0 && slot_used[i] && slot_tag[i] == lk) s = i;
        if (act == ACT_ACQUIRE) begin
            if (s < 0) begin
                for (int i = 0; i < LOCK_SLOTS; i++)
                    if (f < 0 && !slot_used[i]) f = i;
                if (f < 0) begin
                    push_msg(KIND_REPLY, ST_TABLE_FULL, cl, lk, 1'b1);
                    return;
                end
                s = f;
                slot_used[s] = 1'b1;
                slot_tag[s] = lk;
                q_head[s] = 0;
                q_count[s] = 0;
            end
            if (q_count[s] >= QUEUE_DEPTH) begin
                push_msg(KIND_REPLY, ST_QUEUE_FULL, cl, lk, 1'b1);
                return;
            end
            pos = (q_head[s] + q_count[s]) % QUEUE_DEPTH;
            waiters[s][pos] = cl;
            q_count[s]++;
            if (q_count[s] == 1) begin
                push_msg(KIND_REPLY, ST_OK, cl, lk, 1'b1);
            end else begin
                if (q_count[s] == 2)
                    push_msg(KIND_REVOKE, ST_OK, waiters[s][q_head[s]], lk, 1'b0);
                push_msg(KIND_REPLY, ST_RETRY, cl, lk, 1'b1);
            end
            return;
        end
        if (s < 0) begin
            push_msg(KIND_REPLY, ST_NOT_HELD, cl, lk, 1'b1);
            return;
        end
        if (q_count[s] > 0) begin
            q_head[s] = (q_head[s] + 1) % QUEUE_DEPTH;
            q_count[s]--;
        end
        if (q_count[s] > 0) begin
            hd = waiters[s][q_head[s]];
            push_msg(KIND_RETRY, ST_OK, hd, lk, 1'b0);
            if (q_count[s] > 1) push_msg(KIND_REVOKE, ST_OK, hd, lk, 1'b0);
        end else begin
            slot_used[s] = 1'b0;
            q_head[s] = 0;
        end
        push_msg(KIND_REPLY, ST_OK, cl, lk, 1'b1);
    endfunction

    // sends one item, predicting at acceptance
    task automatic send_request(input t_action act, input logic [LOCK_W-1:0] lk,
                                input logic [CLIENT_W-1:0] cl);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.lock_id   <= lk;
        req_ch.client_id <= cl;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_lock_request(act, lk, cl);
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: random stalls, compares each message against the oldest expectation
    always @(posedge i_clk) begin
        t_msg want;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_msgs.size() == 0) begin
                report_mismatch("unexpected message");
            end else begin
                want = pending_msgs[0];
                pending_msgs.delete(0);
                if (rsp_ch.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d want %0d", rsp_ch.kind, want.kind));
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", rsp_ch.status,
                                              want.status));
                if (rsp_ch.target_client !== want.target)
                    report_mismatch($sformatf("target %0d want %0d", rsp_ch.target_client,
                                              want.target));
                if (rsp_ch.lock_of_message !== want.lock_id)
                    report_mismatch($sformatf("lock %h want %h", rsp_ch.lock_of_message,
                                              want.lock_id));
                if (rsp_ch.last !== want.last)
                    report_mismatch($sformatf("last %0d want %0d", rsp_ch.last, want.last));
            end
        end
        rsp_ch.ready <= !i_rst_n ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic wait_drained();
        while (pending_msgs.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // full table, table-full reply, not-held release, then drain it again
    task automatic test_table_limits();
        logic [LOCK_W-1:0] lk;
        for (int i = 0; i < LOCK_SLOTS; i++) begin
            lk = (i == 0) ? '0 : (i == 1) ? '1 : LOCK_W'(64'hA5A5_0000_0000_0000 + i);
            send_request(ACT_ACQUIRE, lk, (i == 1) ? 8'hFF : 8'(i));
        end
        send_request(ACT_ACQUIRE, 64'h1234_5678_9ABC_DEF0, 8'h55);
        send_request(ACT_RELEASE, 64'h1234_5678_9ABC_DEF0, 8'hAA);
        for (int i = 0; i < LOCK_SLOTS; i++) begin
            lk = (i == 0) ? '0 : (i == 1) ? '1 : LOCK_W'(64'hA5A5_0000_0000_0000 + i);
            send_request(ACT_RELEASE, lk, 8'(i + 7));
        end
    endtask

    // queue fill to full, queue-full reply, non-holder releases, repeat acquire
    task automatic test_queue_limits();
        logic [LOCK_W-1:0] lk;
        lk = 64'h8000_0000_0000_0001;
        for (int i = 0; i < QUEUE_DEPTH; i++) send_request(ACT_ACQUIRE, lk, 8'(3 * i));
        send_request(ACT_ACQUIRE, lk, 8'd0);
        for (int i = 0; i < QUEUE_DEPTH / 2; i++) send_request(ACT_RELEASE, lk, 8'hEE);
        send_request(ACT_ACQUIRE, lk, 8'd9);
        send_request(ACT_ACQUIRE, lk, 8'd9);
        for (int i = 0; i < QUEUE_DEPTH; i++) send_request(ACT_RELEASE, lk, 8'(i));
    endtask

    // random traffic over a small pool of locks, plus some fully random ids
    task automatic test_random_traffic(input int n_items);
        logic [LOCK_W-1:0] lk;
        t_action act;
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(9) == 0) lk = {$urandom, $urandom};
            else lk = lock_pool[$urandom_range(23)];
            act = ($urandom_range(99) < 55) ? ACT_ACQUIRE : ACT_RELEASE;
            send_request(act, lk, 8'($urandom));
        end
    endtask

    initial begin
        req_ch.valid = 1'b0;
        req_ch.action = ACT_ACQUIRE;
        req_ch.lock_id = '0;
        req_ch.client_id = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < LOCK_SLOTS; i++) begin
            slot_used[i] = 1'b0; slot_tag[i] = '0; q_head[i] = 0; q_count[i] = 0;
        end
        for (int i = 0; i < 24; i++) lock_pool[i] = {$urandom, $urandom};
        lock_pool[0] = '0;
        lock_pool[1] = '1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_limits();
        test_queue_limits();
        wait_drained();
        test_random_traffic(85);
        wait_drained();
        send_idle_pct = 51;
        test_random_traffic(86);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 51;
        test_random_traffic(86);
        wait_drained();
        send_idle_pct = 21;
        recv_stall_pct = 21;
        test_random_traffic(86);
        wait_drained();
        if (n_errors == 0)
            $display("tb_lock_manager_with_waiter_queues_core OK");
        else
            $display("tb_lock_manager_with_waiter_queues_core NOT OK");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("tb_lock_manager_with_waiter_queues_core NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/lmwq_pkg.sv
hw/rtl/lmwq_if.sv
hw/rtl/lmwq_ram.sv
hw/rtl/lock_manager_with_waiter_queues_core.sv
tb/tb_lock_manager_with_waiter_queues_core.sv
